// ----- rtl/core/bta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

  localparam int ARENA_BYTES = 4096;
  localparam int POOL_W      = 13;
  localparam int ADDR_W      = 18;
  localparam int DATA_W      = 16;
  localparam int ROW_N       = (ARENA_BYTES + 1) / 2;
  localparam int ROW_W       = $clog2(ROW_N);
  localparam int WALK_LIMIT  = ARENA_BYTES / 8 + 2;
  localparam int CNT_W       = $clog2(WALK_LIMIT + 1);
  localparam int POOL_MIN    = 16;
  localparam int POOL_MAX    = (ARENA_BYTES < 4096) ? ARENA_BYTES : 4096;
  localparam int NULL_MARK   = 1;
  localparam int MIN_PAYLOAD = 4;
  localparam int SPLIT_MIN   = 8;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef enum logic [4:0] {
    A_ZERO, A_CLR, A_TWO, A_FOUR, A_SIX, A_EIGHT, A_POOLM2,
    A_CUR, A_CUR2, A_CUR4, A_OFF, A_OFF2, A_OFF4, A_OFFS2, A_P,
    A_NH, A_NH2, A_NH4, A_CURBS2, A_CURNEED2, A_PV, A_PV4, A_PVLINK,
    A_NX2, A_NN2, A_PVPS2
  } asel_t;

  typedef enum logic [3:0] {
    D_ZERO, D_ONE, D_POOL, D_FOUR, D_POOLM8, D_NX, D_PV, D_CUR, D_OFF,
    D_NH, D_REM, D_NEED, D_S, D_NN, D_PS
  } dsel_t;

  typedef enum logic [4:0] {
    L_NONE, L_START, L_NEED, L_CUR_RD, L_CUR_RD_PV1, L_BS_RD, L_NEED_FIT,
    L_PV_RD, L_NX_RD, L_S_RD, L_P4, L_P_ADV, L_WALK, L_CUR_STEP, L_CUR_NULL,
    L_NS_RD, L_NN_RD, L_S_GROW, L_PS_RD, L_PS_GROW, L_CLR_INC, L_CLR0
  } ld_t;

  typedef enum logic [2:0] {
    R_NONE, R_CLEAR, R_NOFIT, R_BADFREE, R_GRANT, R_CHECK1
  } res_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    asel_t asel;
    dsel_t dsel;
    ld_t   ld;
    res_t  res;
    logic  pool_we;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic too_big;
    logic cur_null;
    logic cnt_lim;
    logic cur_link_ok;
    logic fit;
    logic need_eq_bs;
    logic pv_null;
    logic nx_null;
    logic nn_null;
    logic off_ok;
    logic rd_s_ok;
    logic rd_zero;
    logic rd_eq_s;
    logic p_lt_off;
    logic p_eq_off;
    logic rd_p_ok;
    logic cur_lt_off;
    logic merge_next;
    logic merge_prev;
    logic clr_last;
  } flags_t;

endpackage
`default_nettype wire

// ----- rtl/core/bta_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bta_dp import bta_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  input  wire logic [1:0]          opcode,
  input  wire logic [11:0]         request_size,
  input  wire logic [11:0]         block_offset,
  input  wire logic [POOL_W-1:0]   pool_size,
  output flags_t                   flags,
  output logic [1:0]               status,
  output logic [11:0]              granted_offset,
  output logic [11:0]              granted_size,
  output logic                     is_allocated
);

  localparam logic [DATA_W-1:0] NULL_D = DATA_W'(NULL_MARK);

  // arena split into even and odd byte banks so any 16-bit tag is one access
  logic [7:0] even_mem [ROW_N];
  logic [7:0] odd_mem  [ROW_N];

  logic [1:0]        op;
  logic [11:0]       req;
  logic [11:0]       off;
  logic [POOL_W-1:0] pool;
  logic [DATA_W-1:0] need, bs, cur, pv, nx, nn, ns;
  logic [ADDR_W-1:0] p, s, ps;
  logic [CNT_W-1:0]  cnt;
  logic [ROW_W-1:0]  clr;
  logic [1:0]        res_status;
  logic [11:0]       res_gofs, res_gsize;
  logic              res_isal;

  logic [7:0]        ev_q, od_q;
  logic              sw_q, oob_q;
  logic [DATA_W-1:0] rd;
  logic [ADDR_W-1:0] addr, addr_half;
  logic [ROW_W-1:0]  row_a, row_b, ev_idx;
  logic              oob;
  logic [DATA_W-1:0] wdata;

  logic [ADDR_W-1:0] cur_a, off_a, pv_a, pool_a, rd_a, need_a, bs_a, nh_a;
  logic [DATA_W-1:0] need_c, rem;
  logic [POOL_W-1:0] pool_c;
  logic [POOL_W-1:0] pool_in;

  assign cur_a  = ADDR_W'(cur);
  assign off_a  = ADDR_W'(off);
  assign pv_a   = ADDR_W'(pv);
  assign pool_a = ADDR_W'(pool);
  assign rd_a   = ADDR_W'(rd);
  assign need_a = ADDR_W'(need);
  assign bs_a   = ADDR_W'(bs);
  assign nh_a   = cur_a + need_a + ADDR_W'(4);
  assign rem    = bs - need - DATA_W'(4);
  assign need_c = (req < 12'(MIN_PAYLOAD)) ? DATA_W'(MIN_PAYLOAD) : DATA_W'(req);

  always_comb begin
    pool_in = pool_size;
    if (pool_in < POOL_W'(POOL_MIN)) begin
      pool_c = POOL_W'(POOL_MIN);
    end else if (pool_in > POOL_W'(POOL_MAX)) begin
      pool_c = POOL_W'(POOL_MAX);
    end else begin
      pool_c = pool_in;
    end
  end

  always_comb begin
    case (cmd.asel)
      A_ZERO:     addr = '0;
      A_CLR:      addr = ADDR_W'({clr, 1'b0});
      A_TWO:      addr = ADDR_W'(2);
      A_FOUR:     addr = ADDR_W'(4);
      A_SIX:      addr = ADDR_W'(6);
      A_EIGHT:    addr = ADDR_W'(8);
      A_POOLM2:   addr = pool_a - ADDR_W'(2);
      A_CUR:      addr = cur_a;
      A_CUR2:     addr = cur_a + ADDR_W'(2);
      A_CUR4:     addr = cur_a + ADDR_W'(4);
      A_OFF:      addr = off_a;
      A_OFF2:     addr = off_a + ADDR_W'(2);
      A_OFF4:     addr = off_a + ADDR_W'(4);
      A_OFFS2:    addr = off_a + s + ADDR_W'(2);
      A_P:        addr = p;
      A_NH:       addr = nh_a;
      A_NH2:      addr = nh_a + ADDR_W'(2);
      A_NH4:      addr = nh_a + ADDR_W'(4);
      A_CURBS2:   addr = cur_a + bs_a + ADDR_W'(2);
      A_CURNEED2: addr = cur_a + need_a + ADDR_W'(2);
      A_PV:       addr = pv_a;
      A_PV4:      addr = pv_a + ADDR_W'(4);
      A_PVLINK:   addr = (pv == NULL_D) ? ADDR_W'(2) : pv_a + ADDR_W'(4);
      A_NX2:      addr = ADDR_W'(nx) + ADDR_W'(2);
      A_NN2:      addr = ADDR_W'(nn) + ADDR_W'(2);
      A_PVPS2:    addr = pv_a + ps + ADDR_W'(2);
      default:    addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.dsel)
      D_ZERO:   wdata = '0;
      D_ONE:    wdata = NULL_D;
      D_POOL:   wdata = DATA_W'(pool);
      D_FOUR:   wdata = DATA_W'(4);
      D_POOLM8: wdata = DATA_W'(pool) - DATA_W'(8);
      D_NX:     wdata = nx;
      D_PV:     wdata = pv;
      D_CUR:    wdata = cur;
      D_OFF:    wdata = DATA_W'(off);
      D_NH:     wdata = nh_a[DATA_W-1:0];
      D_REM:    wdata = rem;
      D_NEED:   wdata = need;
      D_S:      wdata = s[DATA_W-1:0];
      D_NN:     wdata = nn;
      D_PS:     wdata = ps[DATA_W-1:0];
      default:  wdata = '0;
    endcase
  end

  // a tag at the last byte or beyond reads as zero and is never written
  assign oob       = addr >= ADDR_W'(ARENA_BYTES - 1);
  assign addr_half = addr >> 1;
  assign row_a     = addr_half[ROW_W-1:0];
  assign row_b     = row_a + 1'b1;
  assign ev_idx    = addr[0] ? row_b : row_a;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !oob) begin
      even_mem[ev_idx] <= addr[0] ? wdata[7:0] : wdata[15:8];
      odd_mem[row_a]   <= addr[0] ? wdata[15:8] : wdata[7:0];
    end
    if (cmd.rd_en) begin
      ev_q  <= even_mem[ev_idx];
      od_q  <= odd_mem[row_a];
      sw_q  <= addr[0];
      oob_q <= oob;
    end
  end

  assign rd = oob_q ? '0 : (sw_q ? {od_q, ev_q} : {ev_q, od_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= POOL_W'(POOL_MAX);
      clr  <= '0;
    end else begin
      if (cmd.pool_we) begin
        pool <= pool_c;
      end
      if (cmd.ld == L_CLR0) begin
        clr <= '0;
      end else if (cmd.ld == L_CLR_INC) begin
        clr <= flags.clr_last ? '0 : clr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.ld)
      L_START: begin
        op  <= opcode;
        req <= request_size;
        off <= block_offset;
      end
      L_NEED:       need <= need_c;
      L_CUR_RD: begin
        cur <= rd;
        cnt <= '0;
      end
      L_CUR_RD_PV1: begin
        cur <= rd;
        cnt <= '0;
        pv  <= NULL_D;
      end
      L_BS_RD:      bs <= rd;
      L_NEED_FIT: begin
        if (bs - need < DATA_W'(SPLIT_MIN)) need <= bs;
      end
      L_PV_RD:      pv <= rd;
      L_NX_RD:      nx <= rd;
      L_S_RD:       s <= rd_a;
      L_P4:         p <= ADDR_W'(4);
      L_P_ADV:      p <= p + rd_a + ADDR_W'(4);
      L_WALK:       pv <= cur;
      L_CUR_STEP: begin
        cur <= rd;
        cnt <= cnt + 1'b1;
      end
      L_CUR_NULL:   cur <= NULL_D;
      L_NS_RD:      ns <= rd;
      L_NN_RD:      nn <= rd;
      L_S_GROW:     s <= s + ADDR_W'(ns) + ADDR_W'(4);
      L_PS_RD:      ps <= rd_a;
      L_PS_GROW:    ps <= ps + s + ADDR_W'(4);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      R_CLEAR: begin
        res_status <= ST_OK;
        res_gofs   <= '0;
        res_gsize  <= '0;
        res_isal   <= 1'b0;
      end
      R_NOFIT:   res_status <= ST_NOFIT;
      R_BADFREE: res_status <= ST_BADFREE;
      R_GRANT: begin
        res_status <= ST_OK;
        res_gofs   <= cur[11:0];
        res_gsize  <= need[11:0];
      end
      R_CHECK1:  res_isal <= 1'b1;
      default: ;
    endcase
    if (cmd.out_load) begin
      status         <= res_status;
      granted_offset <= res_gofs;
      granted_size   <= res_gsize;
      is_allocated   <= res_isal;
    end
  end

  always_comb begin
    flags.op          = op;
    flags.too_big     = ADDR_W'(need_c) > pool_a - ADDR_W'(8);
    flags.cur_null    = cur == NULL_D;
    flags.cnt_lim     = cnt == CNT_W'(WALK_LIMIT);
    flags.cur_link_ok = (cur >= DATA_W'(4)) && (cur_a + ADDR_W'(6) <= pool_a);
    flags.fit         = (bs >= need) && (cur_a + bs_a + ADDR_W'(4) <= pool_a);
    flags.need_eq_bs  = need == bs;
    flags.pv_null     = pv == NULL_D;
    flags.nx_null     = nx == NULL_D;
    flags.nn_null     = nn == NULL_D;
    flags.off_ok      = (off >= 12'd4) && (off_a + ADDR_W'(6) <= pool_a);
    flags.rd_s_ok     = (rd >= DATA_W'(MIN_PAYLOAD)) && (off_a + rd_a + ADDR_W'(4) <= pool_a);
    flags.rd_zero     = rd == '0;
    flags.rd_eq_s     = rd_a == s;
    flags.p_lt_off    = p < off_a;
    flags.p_eq_off    = p == off_a;
    flags.rd_p_ok     = (rd >= DATA_W'(MIN_PAYLOAD)) && (p + rd_a + ADDR_W'(4) <= pool_a);
    flags.cur_lt_off  = cur_a < off_a;
    flags.merge_next  = off_a + s + ADDR_W'(4) == cur_a;
    flags.merge_prev  = pv_a + rd_a + ADDR_W'(4) == off_a;
    flags.clr_last    = clr == ROW_W'(ROW_N - 1);
  end

endmodule
`default_nettype wire

// ----- rtl/core/bta_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bta_ctrl import bta_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  wire logic   out_stall,
  input  wire logic   cfg_valid,
  output logic        cfg_ready,
  input  wire flags_t flags,
  output cmd_t        cmd
);

  localparam logic [6:0] S_CLR = 7'd0, S_FM0 = 7'd1, S_FM1 = 7'd2, S_FM2 = 7'd3,
    S_FM3 = 7'd4, S_FM4 = 7'd5, S_FM5 = 7'd6, S_IDLE = 7'd7, S_DISP = 7'd8,
    S_A0 = 7'd9, S_A1 = 7'd10, S_AL = 7'd11, S_A2 = 7'd12, S_A3 = 7'd13,
    S_A4 = 7'd14, S_T1 = 7'd15, S_T2 = 7'd16, S_T3 = 7'd17, S_TE2 = 7'd18,
    S_TS2 = 7'd19, S_TS3 = 7'd20, S_TS4 = 7'd21, S_TS5 = 7'd22, S_TS6 = 7'd23,
    S_TS7 = 7'd24, S_TS8 = 7'd25, S_TZ1 = 7'd26, S_TZ2 = 7'd27,
    S_C0 = 7'd28, S_C1 = 7'd29, S_C2 = 7'd30, S_C3 = 7'd31, S_C4 = 7'd32,
    S_B1 = 7'd33, S_B2 = 7'd34, S_W0 = 7'd35, S_W1 = 7'd36, S_W2 = 7'd37,
    S_W3 = 7'd38, S_W4 = 7'd39, S_L0 = 7'd40, S_L1 = 7'd41, S_L2 = 7'd42,
    S_L3 = 7'd43, S_M0 = 7'd44, S_M1 = 7'd45, S_M2 = 7'd46, S_M3 = 7'd47,
    S_M4 = 7'd48, S_M5 = 7'd49, S_M6 = 7'd50, S_M7 = 7'd51, S_M8 = 7'd52,
    S_M9 = 7'd53, S_M10 = 7'd54, S_Q0 = 7'd55, S_Q1 = 7'd56, S_Q2 = 7'd57,
    S_Q3 = 7'd58, S_Q4 = 7'd59, S_Q5 = 7'd60, S_Q6 = 7'd61, S_Q7 = 7'd62,
    S_Q8 = 7'd63, S_Q9 = 7'd64, S_Q10 = 7'd65, S_DONE = 7'd66;

  logic [6:0] state, state_next;
  logic       fail_free;

  assign in_stall  = !(state == S_IDLE && !cfg_valid);
  assign cfg_ready = (state == S_IDLE) || (state == S_CLR);
  assign fail_free = flags.op == OP_FREE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        if (cfg_valid) begin
          cmd.pool_we = 1'b1;
          cmd.ld      = L_CLR0;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.asel  = A_CLR;
          cmd.dsel  = D_ZERO;
          cmd.ld    = L_CLR_INC;
          if (flags.clr_last) state_next = S_FM0;
        end
      end
      S_FM0: begin
        cmd.wr_en = 1'b1; cmd.asel = A_ZERO; cmd.dsel = D_POOL; state_next = S_FM1;
      end
      S_FM1: begin
        cmd.wr_en = 1'b1; cmd.asel = A_TWO; cmd.dsel = D_FOUR; state_next = S_FM2;
      end
      S_FM2: begin
        cmd.wr_en = 1'b1; cmd.asel = A_FOUR; cmd.dsel = D_POOLM8; state_next = S_FM3;
      end
      S_FM3: begin
        cmd.wr_en = 1'b1; cmd.asel = A_SIX; cmd.dsel = D_ONE; state_next = S_FM4;
      end
      S_FM4: begin
        cmd.wr_en = 1'b1; cmd.asel = A_EIGHT; cmd.dsel = D_ONE; state_next = S_FM5;
      end
      S_FM5: begin
        cmd.wr_en = 1'b1; cmd.asel = A_POOLM2; cmd.dsel = D_POOLM8; state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.pool_we = 1'b1;
          cmd.ld      = L_CLR0;
          state_next  = S_CLR;
        end else if (in_valid) begin
          cmd.ld     = L_START;
          cmd.res    = R_CLEAR;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (flags.op)
          OP_ALLOC: state_next = S_A0;
          OP_FREE:  state_next = S_C0;
          OP_CHECK: state_next = S_C0;
          default:  state_next = S_DONE;
        endcase
      end
      // allocate: first fit along the free list
      S_A0: begin
        if (flags.too_big) begin
          cmd.res = R_NOFIT; state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1; cmd.asel = A_TWO; cmd.ld = L_NEED; state_next = S_A1;
        end
      end
      S_A1: begin
        cmd.ld = L_CUR_RD; state_next = S_AL;
      end
      S_AL: begin
        if (flags.cnt_lim || flags.cur_null || !flags.cur_link_ok) begin
          cmd.res = R_NOFIT; state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1; cmd.asel = A_CUR; state_next = S_A2;
        end
      end
      S_A2: begin
        cmd.ld = L_BS_RD; state_next = S_A3;
      end
      S_A3: begin
        cmd.rd_en = 1'b1;
        if (flags.fit) begin
          cmd.asel = A_CUR2; cmd.ld = L_NEED_FIT; state_next = S_T1;
        end else begin
          cmd.asel = A_CUR4; state_next = S_A4;
        end
      end
      S_A4: begin
        cmd.ld = L_CUR_STEP; state_next = S_AL;
      end
      S_T1: begin
        cmd.ld = L_PV_RD; cmd.rd_en = 1'b1; cmd.asel = A_CUR4; state_next = S_T2;
      end
      S_T2: begin
        cmd.ld = L_NX_RD; state_next = S_T3;
      end
      S_T3: begin
        cmd.wr_en = 1'b1;
        if (flags.need_eq_bs) begin
          cmd.asel = A_PVLINK; cmd.dsel = D_NX; state_next = S_TE2;
        end else begin
          cmd.asel = A_NH; cmd.dsel = D_REM; state_next = S_TS2;
        end
      end
      S_TE2: begin
        cmd.wr_en = !flags.nx_null; cmd.asel = A_NX2; cmd.dsel = D_PV; state_next = S_TZ1;
      end
      S_TS2: begin
        cmd.wr_en = 1'b1; cmd.asel = A_NH2; cmd.dsel = D_PV; state_next = S_TS3;
      end
      S_TS3: begin
        cmd.wr_en = 1'b1; cmd.asel = A_NH4; cmd.dsel = D_NX; state_next = S_TS4;
      end
      S_TS4: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CURBS2; cmd.dsel = D_REM; state_next = S_TS5;
      end
      S_TS5: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CUR; cmd.dsel = D_NEED; state_next = S_TS6;
      end
      S_TS6: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CURNEED2; cmd.dsel = D_NEED; state_next = S_TS7;
      end
      S_TS7: begin
        cmd.wr_en = 1'b1; cmd.asel = A_PVLINK; cmd.dsel = D_NH; state_next = S_TS8;
      end
      S_TS8: begin
        cmd.wr_en = !flags.nx_null; cmd.asel = A_NX2; cmd.dsel = D_NH; state_next = S_TZ1;
      end
      S_TZ1: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CUR2; cmd.dsel = D_ZERO; state_next = S_TZ2;
      end
      S_TZ2: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CUR4; cmd.dsel = D_ZERO;
        cmd.res = R_GRANT; state_next = S_DONE;
      end
      // tag check, shared by free and check
      S_C0: begin
        if (!flags.off_ok) begin
          cmd.res = fail_free ? R_BADFREE : R_NONE; state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1; cmd.asel = A_OFF; state_next = S_C1;
        end
      end
      S_C1: begin
        if (!flags.rd_s_ok) begin
          cmd.res = fail_free ? R_BADFREE : R_NONE; state_next = S_DONE;
        end else begin
          cmd.ld = L_S_RD; cmd.rd_en = 1'b1; cmd.asel = A_OFF2; state_next = S_C2;
        end
      end
      S_C2: begin
        if (!flags.rd_zero) begin
          cmd.res = fail_free ? R_BADFREE : R_NONE; state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1; cmd.asel = A_OFF4; state_next = S_C3;
        end
      end
      S_C3: begin
        if (!flags.rd_zero) begin
          cmd.res = fail_free ? R_BADFREE : R_NONE; state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1; cmd.asel = A_OFFS2; state_next = S_C4;
        end
      end
      S_C4: begin
        if (!flags.rd_eq_s) begin
          cmd.res = fail_free ? R_BADFREE : R_NONE; state_next = S_DONE;
        end else if (!fail_free) begin
          cmd.res = R_CHECK1; state_next = S_DONE;
        end else begin
          cmd.ld = L_P4; state_next = S_B1;
        end
      end
      // walk block sizes from the first block to confirm the boundary
      S_B1: begin
        if (flags.p_lt_off) begin
          cmd.rd_en = 1'b1; cmd.asel = A_P; state_next = S_B2;
        end else if (flags.p_eq_off) begin
          state_next = S_W0;
        end else begin
          cmd.res = R_BADFREE; state_next = S_DONE;
        end
      end
      S_B2: begin
        if (!flags.rd_p_ok) begin
          cmd.res = R_BADFREE; state_next = S_DONE;
        end else begin
          cmd.ld = L_P_ADV; state_next = S_B1;
        end
      end
      // find the list neighbors in address order
      S_W0: begin
        cmd.rd_en = 1'b1; cmd.asel = A_TWO; state_next = S_W1;
      end
      S_W1: begin
        cmd.ld = L_CUR_RD_PV1; state_next = S_W2;
      end
      S_W2: begin
        if (!flags.cnt_lim && !flags.cur_null && flags.cur_lt_off) begin
          if (!flags.cur_link_ok) begin
            cmd.ld = L_CUR_NULL; state_next = S_L0;
          end else begin
            cmd.ld = L_WALK; cmd.rd_en = 1'b1; cmd.asel = A_CUR4; state_next = S_W3;
          end
        end else begin
          state_next = S_W4;
        end
      end
      S_W3: begin
        cmd.ld = L_CUR_STEP; state_next = S_W2;
      end
      S_W4: begin
        if (!flags.cur_null && (!flags.cur_link_ok || flags.cur_lt_off)) begin
          cmd.ld = L_CUR_NULL;
        end
        state_next = S_L0;
      end
      S_L0: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF2; cmd.dsel = D_PV; state_next = S_L1;
      end
      S_L1: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF4; cmd.dsel = D_CUR; state_next = S_L2;
      end
      S_L2: begin
        cmd.wr_en = 1'b1; cmd.asel = A_PVLINK; cmd.dsel = D_OFF; state_next = S_L3;
      end
      S_L3: begin
        cmd.wr_en = !flags.cur_null; cmd.asel = A_CUR2; cmd.dsel = D_OFF;
        state_next = (!flags.cur_null && flags.merge_next) ? S_M0 : S_Q0;
      end
      // merge with the following free block
      S_M0: begin
        cmd.rd_en = 1'b1; cmd.asel = A_CUR; state_next = S_M1;
      end
      S_M1: begin
        cmd.ld = L_NS_RD; cmd.rd_en = 1'b1; cmd.asel = A_CUR4; state_next = S_M2;
      end
      S_M2: begin
        cmd.ld = L_NN_RD; state_next = S_M3;
      end
      S_M3: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFFS2; cmd.dsel = D_ZERO; state_next = S_M4;
      end
      S_M4: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CUR; cmd.dsel = D_ZERO; state_next = S_M5;
      end
      S_M5: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CUR2; cmd.dsel = D_ZERO; state_next = S_M6;
      end
      S_M6: begin
        cmd.wr_en = 1'b1; cmd.asel = A_CUR4; cmd.dsel = D_ZERO;
        cmd.ld = L_S_GROW; state_next = S_M7;
      end
      S_M7: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF; cmd.dsel = D_S; state_next = S_M8;
      end
      S_M8: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF4; cmd.dsel = D_NN; state_next = S_M9;
      end
      S_M9: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFFS2; cmd.dsel = D_S; state_next = S_M10;
      end
      S_M10: begin
        cmd.wr_en = !flags.nn_null; cmd.asel = A_NN2; cmd.dsel = D_OFF; state_next = S_Q0;
      end
      // merge into the preceding free block
      S_Q0: begin
        if (flags.pv_null) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1; cmd.asel = A_PV; state_next = S_Q1;
        end
      end
      S_Q1: begin
        if (flags.merge_prev) begin
          cmd.ld = L_PS_RD; cmd.rd_en = 1'b1; cmd.asel = A_OFF4; state_next = S_Q2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_Q2: begin
        cmd.ld = L_NN_RD; state_next = S_Q3;
      end
      S_Q3: begin
        cmd.wr_en = 1'b1; cmd.asel = A_PVPS2; cmd.dsel = D_ZERO; state_next = S_Q4;
      end
      S_Q4: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF; cmd.dsel = D_ZERO; state_next = S_Q5;
      end
      S_Q5: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF2; cmd.dsel = D_ZERO; state_next = S_Q6;
      end
      S_Q6: begin
        cmd.wr_en = 1'b1; cmd.asel = A_OFF4; cmd.dsel = D_ZERO;
        cmd.ld = L_PS_GROW; state_next = S_Q7;
      end
      S_Q7: begin
        cmd.wr_en = 1'b1; cmd.asel = A_PV; cmd.dsel = D_PS; state_next = S_Q8;
      end
      S_Q8: begin
        cmd.wr_en = 1'b1; cmd.asel = A_PV4; cmd.dsel = D_NN; state_next = S_Q9;
      end
      S_Q9: begin
        cmd.wr_en = 1'b1; cmd.asel = A_PVPS2; cmd.dsel = D_PS; state_next = S_Q10;
      end
      S_Q10: begin
        cmd.wr_en = !flags.nn_null; cmd.asel = A_NN2; cmd.dsel = D_PV; state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/boundary_tag_first_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Boundary-tag first-fit allocator over a 4096-byte arena.
// Input channel (in_valid/in_stall) carries opcode, request_size and
// block_offset; one result beat per request leaves on the output channel
// (out_valid/out_stall) as status, granted_offset, granted_size, is_allocated.
// The config channel (cfg_valid/cfg_ready) writes pool_size, clamped to
// 16..4096, and reformats the arena as one free block.
// Requests are processed one at a time by a microcoded sequencer with one arena
// port (16-bit tag per access, registered read data). Allocate time grows with
// each free-list node skipped and with a split; an oversized request is rejected
// before the free list is read. Free time grows with the blocks on the boundary
// walk, the free-list nodes before the block, a preceding free block and each
// merge with a neighbour. Check reads only the tags of the given block.
// The result sits in an output register: the next request is accepted while
// it waits, but the following result cannot be loaded until it is taken.
// Reset and every pool_size write clear the arena one 16-bit row per cycle while
// cfg_valid is low, then write the format tags, with in_stall held high meanwhile.
module boundary_tag_first_fit_allocator import bta_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        opcode,
  input  wire logic [11:0]       request_size,
  input  wire logic [11:0]       block_offset,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [11:0]            granted_offset,
  output logic [11:0]            granted_size,
  output logic                   is_allocated,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [POOL_W-1:0] pool_size
);

  cmd_t   cmd;
  flags_t flags;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  bta_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .opcode         (opcode),
    .request_size   (request_size),
    .block_offset   (block_offset),
    .pool_size      (pool_size),
    .flags          (flags),
    .status         (status),
    .granted_offset (granted_offset),
    .granted_size   (granted_size),
    .is_allocated   (is_allocated)
  );

endmodule
`default_nettype wire

// ----- rtl/core/bta_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bta_checker import bta_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [1:0]        opcode,
  input wire logic [11:0]       request_size,
  input wire logic [11:0]       block_offset,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        status,
  input wire logic [11:0]       granted_offset,
  input wire logic [11:0]       granted_size,
  input wire logic              is_allocated,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic [POOL_W-1:0] pool_size
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(granted_offset) && $stable(granted_size) && $stable(is_allocated))
    else $error("result beat changed under stall");

  // arena is being reformatted right after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input accepted during arena clear");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_offset == '0 && granted_size == '0 &&
      !is_allocated)
    else $error("failed request carries a grant");

  a_grant_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted_size != '0 |-> status == ST_OK && granted_offset >= 12'd4 &&
      granted_size >= 12'd4 && !is_allocated)
    else $error("malformed grant");

endmodule

bind boundary_tag_first_fit_allocator bta_checker u_bta_checker (.*);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bta_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned ITEMS_PER_PHASE = 190;

  typedef struct {
    logic [1:0]  st;
    logic [11:0] goff;
    logic [11:0] gsz;
    logic        alloc_bit;
  } result_t;

  // Tag-level model of the arena plus the queue of results still owed.
  class arena_scoreboard;
    byte unsigned mem[ARENA_BYTES];
    int unsigned pool;
    result_t owed[$];
    int unsigned live[$];
    int errors;
    int results_seen;
    int n_alloc, n_free, n_check, n_nofit, n_badfree;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function int unsigned rd16(int unsigned i);
      if (i + 1 >= ARENA_BYTES) return 0;
      return {mem[i], mem[i + 1]};
    endfunction

    function void wr16(int unsigned i, int unsigned v);
      if (i + 1 >= ARENA_BYTES) return;
      mem[i] = v[15:8];
      mem[i + 1] = v[7:0];
    endfunction

    function void format(logic [POOL_W-1:0] v);
      pool = 32'(v);
      if (pool < POOL_MIN) pool = POOL_MIN;
      if (pool > POOL_MAX) pool = POOL_MAX;
      foreach (mem[i]) mem[i] = 0;
      wr16(0, pool);
      wr16(2, 4);
      wr16(4, pool - 8);
      wr16(6, NULL_MARK);
      wr16(8, NULL_MARK);
      wr16(pool - 2, pool - 8);
      live.delete();
    endfunction

    function bit tags_alloc(int unsigned off);
      int unsigned s;
      if (off < 4 || off + 6 > pool) return 0;
      s = rd16(off);
      if (s < MIN_PAYLOAD || off + s + 4 > pool) return 0;
      return rd16(off + 2) == 0 && rd16(off + 4) == 0 && rd16(off + s + 2) == s;
    endfunction

    function bit on_boundary(int unsigned off);
      int unsigned p, s;
      p = 4;
      while (p < off) begin
        s = rd16(p);
        if (s < MIN_PAYLOAD || p + s + 4 > pool) return 0;
        p += s + 4;
      end
      return p == off;
    endfunction

    function bit link_ok(int unsigned b);
      return b >= 4 && b + 6 <= pool;
    endfunction

    function void carve(int unsigned b, int unsigned need);
      int unsigned bs, pv, nx, nh, rem;
      bs = rd16(b);
      pv = rd16(b + 2);
      nx = rd16(b + 4);
      if (need == bs) begin
        if (pv == NULL_MARK) wr16(2, nx); else wr16(pv + 4, nx);
        if (nx != NULL_MARK) wr16(nx + 2, pv);
      end else begin
        nh = b + need + 4;
        rem = bs - need - 4;
        wr16(nh, rem);
        wr16(nh + 2, pv);
        wr16(nh + 4, nx);
        wr16(b + bs + 2, rem);
        wr16(b, need);
        wr16(b + need + 2, need);
        if (pv == NULL_MARK) wr16(2, nh); else wr16(pv + 4, nh);
        if (nx != NULL_MARK) wr16(nx + 2, nh);
      end
      wr16(b + 2, 0);
      wr16(b + 4, 0);
    endfunction

    function bit first_fit(int unsigned req, output int unsigned where,
                           output int unsigned given);
      int unsigned need, cur, bs;
      need = req < MIN_PAYLOAD ? MIN_PAYLOAD : req;
      cur = rd16(2);
      where = 0;
      given = 0;
      if (need > pool - 8) return 0;
      for (int n = 0; n < WALK_LIMIT && cur != NULL_MARK; n++) begin
        if (!link_ok(cur)) return 0;
        bs = rd16(cur);
        if (bs >= need && cur + bs + 4 <= pool) begin
          if (bs - need < SPLIT_MIN) need = bs;
          carve(cur, need);
          where = cur;
          given = need;
          return 1;
        end
        cur = rd16(cur + 4);
      end
      return 0;
    endfunction

    function bit release_block(int unsigned off);
      int unsigned s, pv, cur, ns, nn, ps;
      pv = NULL_MARK;
      if (!tags_alloc(off) || !on_boundary(off)) return 0;
      s = rd16(off);
      cur = rd16(2);
      for (int n = 0; n < WALK_LIMIT && cur != NULL_MARK && cur < off; n++) begin
        if (!link_ok(cur)) begin
          cur = NULL_MARK;
          break;
        end
        pv = cur;
        cur = rd16(cur + 4);
      end
      if (cur != NULL_MARK && (!link_ok(cur) || cur < off)) cur = NULL_MARK;
      wr16(off + 2, pv);
      wr16(off + 4, cur);
      if (pv == NULL_MARK) wr16(2, off); else wr16(pv + 4, off);
      if (cur != NULL_MARK) wr16(cur + 2, off);
      // coalesce with the following free block
      if (cur != NULL_MARK && off + s + 4 == cur) begin
        ns = rd16(cur);
        nn = rd16(cur + 4);
        wr16(off + s + 2, 0);
        wr16(cur, 0);
        wr16(cur + 2, 0);
        wr16(cur + 4, 0);
        s = s + ns + 4;
        wr16(off, s);
        wr16(off + 4, nn);
        wr16(off + s + 2, s);
        if (nn != NULL_MARK) wr16(nn + 2, off);
      end
      // then with the preceding one
      if (pv != NULL_MARK) begin
        ps = rd16(pv);
        if (pv + ps + 4 == off) begin
          nn = rd16(off + 4);
          wr16(pv + ps + 2, 0);
          wr16(off, 0);
          wr16(off + 2, 0);
          wr16(off + 4, 0);
          ps = ps + s + 4;
          wr16(pv, ps);
          wr16(pv + 4, nn);
          wr16(pv + ps + 2, ps);
          if (nn != NULL_MARK) wr16(nn + 2, pv);
        end
      end
      return 1;
    endfunction

    function void note(logic [1:0] op, logic [11:0] req, logic [11:0] off);
      result_t r;
      int unsigned w, g;
      r = '{ST_OK, 12'd0, 12'd0, 1'b0};
      if (op == OP_ALLOC) begin
        n_alloc++;
        if (first_fit(req, w, g)) begin
          r.goff = 12'(w);
          r.gsz = 12'(g);
          live.push_back(w);
        end else begin
          r.st = ST_NOFIT;
          n_nofit++;
        end
      end else if (op == OP_FREE) begin
        n_free++;
        if (release_block(off)) begin
          foreach (live[i]) if (live[i] == off) begin
            live.delete(i);
            break;
          end
        end else begin
          r.st = ST_BADFREE;
          n_badfree++;
        end
      end else if (op == OP_CHECK) begin
        n_check++;
        r.alloc_bit = tags_alloc(off);
      end
      owed.push_back(r);
    endfunction

    task check(result_t got);
      result_t e;
      results_seen++;
      if (owed.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = owed.pop_front();
      if (got.st !== e.st)
        report($sformatf("status %0d, expected %0d", got.st, e.st));
      if (got.goff !== e.goff)
        report($sformatf("granted_offset %0d, expected %0d", got.goff, e.goff));
      if (got.gsz !== e.gsz)
        report($sformatf("granted_size %0d, expected %0d", got.gsz, e.gsz));
      if (got.alloc_bit !== e.alloc_bit)
        report($sformatf("is_allocated %0d, expected %0d", got.alloc_bit, e.alloc_bit));
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic [11:0] request_size, block_offset;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [11:0] granted_offset, granted_size;
  logic is_allocated;
  logic cfg_valid, cfg_ready;
  logic [POOL_W-1:0] pool_size;

  arena_scoreboard sb;
  bit quiet;
  bit hold_done;
  int unsigned cycles;

  boundary_tag_first_fit_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .request_size(request_size), .block_offset(block_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .granted_offset(granted_offset),
    .granted_size(granted_size), .is_allocated(is_allocated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_size(pool_size)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off, checking
  initial begin
    int hold;
    result_t got;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{status, granted_offset, granted_size, is_allocated};
        sb.check(got);
      end
      if (hold > 0) begin
        hold--;
        out_stall <= hold > 0;
      end else if (!hold_done && sb.results_seen >= 100) begin
        hold_done = 1;
        hold = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 12);
      end
    end
  end

  task send(logic [1:0] op, logic [11:0] req, logic [11:0] off);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    request_size <= req;
    block_offset <= off;
    do @(posedge clk); while (in_stall);
    sb.note(op, req, off);
  endtask

  task settle();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_pool(logic [POOL_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    pool_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.format(v);
  endtask

  function logic [11:0] pick_live();
    if (sb.live.size() == 0) return 12'($urandom_range(0, 4095));
    return 12'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
  endfunction

  task random_item();
    int r;
    logic [11:0] sz, off;
    r = $urandom_range(0, 99);
    sz = 12'($urandom_range(0, 99) < 80 ? $urandom_range(0, 48) :
         ($urandom_range(0, 3) != 0 ? $urandom_range(0, 300) : $urandom_range(0, 4095)));
    off = 12'($urandom_range(0, 4095));
    if (r < 45) begin
      send(OP_ALLOC, sz, off);
    end else if (r < 82) begin
      r = $urandom_range(0, 99);
      if (r < 80) off = pick_live();
      else if (r < 90) off = 12'(pick_live() + $urandom_range(1, 8));
      send(OP_FREE, sz, off);
    end else if (r < 96) begin
      if ($urandom_range(0, 1)) off = pick_live();
      send(OP_CHECK, sz, off);
    end else begin
      send(OP_NONE, sz, off);
    end
  endtask

  initial begin
    logic [11:0] a, b, c;
    logic [POOL_W-1:0] sizes[6];
    sb = new();
    sizes = '{13'd16, 13'd8191, 13'd0, 13'd100, 13'd512, 13'd4096};
    quiet = 0;
    hold_done = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_ALLOC;
    request_size <= '0;
    block_offset <= '0;
    cfg_valid <= 1'b0;
    pool_size <= '0;
    sb.format(13'd4096);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: minimum and exact sizes, splits, merges, bad frees, checks
    send(OP_ALLOC, 12'd0, 12'd0);
    send(OP_ALLOC, 12'd3, 12'd0);
    send(OP_ALLOC, 12'd20, 12'd0);
    send(OP_ALLOC, 12'd100, 12'd0);
    a = 12'(sb.live[0]); b = 12'(sb.live[1]); c = 12'(sb.live[2]);
    send(OP_CHECK, 12'd0, b);
    send(OP_FREE, 12'd0, b);
    send(OP_FREE, 12'd0, b);
    send(OP_CHECK, 12'd0, b);
    send(OP_FREE, 12'd0, 12'd0);
    send(OP_FREE, 12'd0, 12'd4095);
    send(OP_FREE, 12'd0, 12'd5);
    send(OP_CHECK, 12'd0, 12'd4095);
    send(OP_CHECK, 12'd0, 12'd0);
    send(OP_NONE, 12'hFFF, 12'hFFF);
    send(OP_ALLOC, 12'd4095, 12'd0);
    send(OP_ALLOC, 12'd4089, 12'd0);
    send(OP_FREE, 12'd0, a);
    send(OP_FREE, 12'd0, c);
    send(OP_FREE, 12'd0, 12'(sb.live[0]));
    send(OP_ALLOC, 12'd4088, 12'd0);
    send(OP_FREE, 12'd0, 12'd4);
    send(OP_ALLOC, 12'd4080, 12'd0);

    for (int ph = 0; ph < 7; ph++) begin
      quiet = (ph == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
      if (ph < 6) write_pool(sizes[ph]);
      // a tiny pool: only exact or whole-block grants fit
      if (ph == 0) begin
        send(OP_ALLOC, 12'd4, 12'd0);
        send(OP_ALLOC, 12'd9, 12'd0);
      end
    end

    settle();
    $display("ran %0d results: %0d allocs (%0d no fit), %0d frees (%0d rejected), %0d checks",
             sb.results_seen, sb.n_alloc, sb.n_nofit, sb.n_free, sb.n_badfree, sb.n_check);
    $display("pool sizes 16..4096 incl. clamped writes, one long output hold-off");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
